FILE: hw/rtl/pqed_pkg.sv
// ----------------------------------------------------------------------------
// Palette quantizer package
// Shared field widths, request codes, register indexes and the structs that
// pass between the palette search and the top level.
// ----------------------------------------------------------------------------
package pqed_pkg;

  localparam int COMP_W     = 8;
  localparam int INDEX_W    = 8;
  localparam int OP_W       = 2;
  localparam int ENTRIES_W  = 9;
  localparam int IMG_W_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int S_DATA_W   = 32;
  localparam int M_DATA_W   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_PIXEL = 2'd2
  } op_code_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 2'd2;

  localparam logic [ENTRIES_W-1:0] ENTRIES_RST     = 9'd256;
  localparam logic [INDEX_W-1:0]   TRANSPARENT_RST = 8'd0;
  localparam logic [IMG_W_W-1:0]   WIDTH_RST       = 13'd4096;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic               done;
    logic               found;
    logic [INDEX_W-1:0] index;
  } search_status_t;

endpackage

FILE: hw/rtl/pqed_column_store.sv
// ----------------------------------------------------------------------------
// Column error store
// One entry of three saturated error accumulators per column, with a
// registered read port, one write port and a clearing sweep after reset or
// on request.
// ----------------------------------------------------------------------------
module pqed_column_store #(
  parameter int MAX_WIDTH  = 4096,
  parameter int ERROR_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  output logic                          busy,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  output logic [3*ERROR_BITS-1:0]       rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
  input  logic [3*ERROR_BITS-1:0]       wr_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [AW-1:0] LAST = AW'(MAX_WIDTH - 1);

  logic [3*ERROR_BITS-1:0] mem [MAX_WIDTH];
  logic                    sweeping;
  logic [AW-1:0]           clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping <= 1'b1;
      clr_addr <= '0;
    end else if (clear) begin
      sweeping <= 1'b1;
      clr_addr <= '0;
    end else if (sweeping) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST) begin
        sweeping <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweeping) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = sweeping;

endmodule

FILE: hw/rtl/pqed_palette_search.sv
// ----------------------------------------------------------------------------
// Palette search unit
// Holds the palette and walks it one entry per cycle, computing the L1
// distance to the target color and keeping the lowest-index nearest entry.
// Also resolves the transparent index into the palette range for the case
// where no entry qualifies.
// ----------------------------------------------------------------------------
module pqed_palette_search #(
  parameter int PALETTE_DEPTH = 256,
  parameter int ERROR_BITS    = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ERROR_BITS:0]         tgt_red,
  input  logic signed [ERROR_BITS:0]         tgt_green,
  input  logic signed [ERROR_BITS:0]         tgt_blue,
  input  logic [pqed_pkg::ENTRIES_W-1:0]     palette_entries,
  input  logic [pqed_pkg::INDEX_W-1:0]       transparent_index,
  input  logic                               wr_en,
  input  logic [pqed_pkg::INDEX_W-1:0]       wr_index,
  input  pqed_pkg::rgb_t                     wr_rgb,
  input  logic                               fetch,
  input  logic [pqed_pkg::INDEX_W-1:0]       fetch_index,
  output pqed_pkg::rgb_t                     rd_rgb,
  output pqed_pkg::search_status_t           status
);

  import pqed_pkg::*;

  localparam int PA_BITS = $clog2(PALETTE_DEPTH);
  localparam int TB      = ERROR_BITS + 1;
  localparam int DB      = TB + 2;
  localparam logic [ENTRIES_W-1:0] DEPTH_N = ENTRIES_W'(PALETTE_DEPTH);

  rgb_t                 mem [PALETTE_DEPTH];
  logic [PA_BITS-1:0]   rd_addr;
  logic [ENTRIES_W-1:0] count;
  logic [ENTRIES_W-1:0] count_lat;
  logic [ENTRIES_W-1:0] idx;
  logic [ENTRIES_W-1:0] mod_val;
  logic [INDEX_W-1:0]   transp;
  logic                 run;
  logic                 active;
  logic                 a_valid;
  logic                 a_skip;
  logic                 b_valid;
  logic                 best_found;
  logic                 drained;
  logic [PA_BITS-1:0]   a_idx;
  logic [PA_BITS-1:0]   b_idx;
  logic [PA_BITS-1:0]   best_idx;
  logic [DB-1:0]        l1_dist;
  logic [DB-1:0]        b_dist;
  logic [DB-1:0]        best_dist;

  function automatic logic [TB-1:0] absdiff(input logic signed [TB-1:0] t,
                                            input logic [COMP_W-1:0] c);
    logic signed [TB:0] e;
    e = (TB+1)'(t) - (TB+1)'($signed({1'b0, c}));
    return e[TB] ? TB'(-e) : TB'(e);
  endfunction

  assign count   = (palette_entries > DEPTH_N) ? DEPTH_N : palette_entries;
  assign rd_addr = fetch ? fetch_index[PA_BITS-1:0] : idx[PA_BITS-1:0];
  assign l1_dist = DB'(absdiff(tgt_red, rd_rgb.red))
                 + DB'(absdiff(tgt_green, rd_rgb.green))
                 + DB'(absdiff(tgt_blue, rd_rgb.blue));
  assign drained = !active && !a_valid && !b_valid && (mod_val < DEPTH_N);

  always_comb begin
    status.done  = run && drained;
    status.found = best_found;
    status.index = best_found ? INDEX_W'(best_idx) : mod_val[INDEX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en && (ENTRIES_W'(wr_index) < DEPTH_N)) begin
      mem[wr_index[PA_BITS-1:0]] <= wr_rgb;
    end
    rd_rgb <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run        <= 1'b0;
      active     <= 1'b0;
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      best_found <= 1'b0;
    end else if (start) begin
      run        <= 1'b1;
      active     <= 1'b1;
      idx        <= '0;
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      best_found <= 1'b0;
      mod_val    <= ENTRIES_W'(transparent_index);
      transp     <= transparent_index;
      count_lat  <= count;
    end else begin
      if (run && drained) begin
        run <= 1'b0;
      end
      if (active && (idx < count_lat)) begin
        a_valid <= 1'b1;
        a_skip  <= (idx == ENTRIES_W'(transp));
        a_idx   <= idx[PA_BITS-1:0];
        idx     <= idx + ENTRIES_W'(1);
      end else begin
        active  <= 1'b0;
        a_valid <= 1'b0;
      end
      b_valid <= a_valid && !a_skip;
      b_dist  <= l1_dist;
      b_idx   <= a_idx;
      if (b_valid && (!best_found || (b_dist < best_dist))) begin
        best_found <= 1'b1;
        best_dist  <= b_dist;
        best_idx   <= b_idx;
      end
      if (mod_val >= DEPTH_N) begin
        mod_val <= mod_val - DEPTH_N;
      end
    end
  end

  a_no_transparent: assert property (@(posedge clk) disable iff (rst)
    (status.done && status.found) |-> (status.index != transp))
    else $error("Search picked the transparent entry.");

  a_start_not_done: assert property (@(posedge clk) disable iff (rst)
    start |=> !status.done)
    else $error("Search reported done right after start.");

endmodule

FILE: hw/rtl/palette_quantizer_error_diffusion_core.sv
// ----------------------------------------------------------------------------
// Palette quantizer with serpentine error diffusion
// Maps RGB pixels to the nearest loaded palette entry by L1 distance while
// diffusing the quantization error through row and column accumulators.
// ----------------------------------------------------------------------------
// The s_ channel carries requests: tuser selects a palette load, an image
// start or a pixel. Pixels come in processing order, even rows left to
// right and odd rows right to left. Each pixel yields one result on the m_
// channel with the chosen index and its color; loads and starts yield none.
// The cfg channel writes the entry count, the transparent index and the
// image width, and is always ready.
// A palette load is written into the palette memory as it is taken. A
// pixel's search covers palette_entries entries (capped at PALETTE_DEPTH),
// and the next request is taken once its result is in the output register;
// the search reads one palette entry per cycle through the single read
// port of the palette memory. The transparent index is reduced into the
// palette range by repeated subtraction from the search start, which
// lengthens a pixel only when the search itself is shorter.
// Reset and every image start run a clearing pass over all MAX_WIDTH
// entries of the column store, during which s_tready stays low.
// A finished result waits in the output register; while the receiver
// stalls, loads and image starts are still taken, and the next pixel is
// processed up to the point where its result would be written.
// ----------------------------------------------------------------------------
module palette_quantizer_error_diffusion_core #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256,
  parameter int ERROR_BITS    = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // entry_index, red, green, blue
  input  logic [pqed_pkg::S_DATA_W-1:0]      s_tdata,
  // op
  input  logic [pqed_pkg::OP_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // color_index, out_red, out_green, out_blue
  output logic [pqed_pkg::M_DATA_W-1:0]      m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pqed_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pqed_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import pqed_pkg::*;

  localparam int EB      = ERROR_BITS;
  localparam int TB      = EB + 1;
  localparam int CA_BITS = $clog2(MAX_WIDTH);
  localparam int WV_BITS = $clog2(MAX_WIDTH + 1);
  localparam int WC      = (WV_BITS > IMG_W_W) ? WV_BITS : IMG_W_W;
  localparam logic signed [EB+1:0] SAT_HI = (EB+2)'((1 << (EB - 1)) - 1);
  localparam logic signed [EB+1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_COLRD,
    ST_ERR,
    ST_START,
    ST_SEARCH,
    ST_FETCH,
    ST_APPLY,
    ST_PUSH
  } state_t;

  state_t               state;
  logic [ENTRIES_W-1:0] palette_entries;
  logic [INDEX_W-1:0]   transparent_index;
  logic [IMG_W_W-1:0]   image_width;
  logic [CA_BITS-1:0]   pos;
  logic                 odd;
  logic signed [EB-1:0] row_err [3];
  logic signed [EB-1:0] colv [3];
  logic signed [TB-1:0] tgt [3];
  logic [COMP_W-1:0]    pix [3];
  logic [INDEX_W-1:0]   sel;
  logic [INDEX_W-1:0]   res_index;
  rgb_t                 res_rgb;

  logic [WC-1:0]        width_raw;
  logic [WC-1:0]        width_eff;
  logic [WC-1:0]        col_wide;
  logic [CA_BITS-1:0]   col_v;
  logic                 col_busy;
  logic                 col_clear;
  logic [3*EB-1:0]      col_rd;
  logic [3*EB-1:0]      col_wr;
  logic                 col_we;
  logic                 pal_wr;
  logic                 search_start;
  logic                 pal_fetch;
  rgb_t                 pal_wr_rgb;
  rgb_t                 rd_rgb;
  search_status_t       status;
  logic [COMP_W-1:0]    pal_c [3];

  logic signed [EB-1:0] col_ch [3];
  logic signed [EB:0]   sum_v [3];
  logic signed [EB:0]   err_v [3];
  logic signed [EB+1:0] diff_v [3];
  logic signed [EB-1:0] row_sub [3];
  logic signed [EB-1:0] col_sub [3];
  logic signed [EB-1:0] row_add [3];
  logic signed [EB-1:0] col_add [3];
  logic signed [TB-1:0] tgt_v [3];

  function automatic logic signed [EB-1:0] sat_err(input logic signed [EB+1:0] v);
    return (v > SAT_HI) ? SAT_HI[EB-1:0] : ((v < SAT_LO) ? SAT_LO[EB-1:0] : v[EB-1:0]);
  endfunction

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign pal_wr       = s_tvalid && s_tready && (s_tuser == OP_LOAD);
  assign col_clear    = s_tvalid && s_tready && (s_tuser == OP_START);
  assign search_start = (state == ST_START);
  assign pal_fetch    = (state == ST_FETCH);
  assign col_we       = (state == ST_APPLY);
  assign pal_wr_rgb   = '{red: s_tdata[15:8], green: s_tdata[23:16], blue: s_tdata[31:24]};
  assign pal_c[0]     = rd_rgb.red;
  assign pal_c[1]     = rd_rgb.green;
  assign pal_c[2]     = rd_rgb.blue;
  assign col_wr       = {col_add[2], col_add[1], col_add[0]};

  always_comb begin
    width_raw = (image_width == '0) ? WC'(1) : WC'(image_width);
    width_eff = (width_raw > WC'(MAX_WIDTH)) ? WC'(MAX_WIDTH) : width_raw;
    col_wide  = odd ? (width_eff - WC'(1) - WC'(pos)) : WC'(pos);
    col_v     = col_wide[CA_BITS-1:0];
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      col_ch[ch]  = $signed(col_rd[ch*EB +: EB]);
      sum_v[ch]   = (EB+1)'(row_err[ch]) + (EB+1)'(col_ch[ch]);
      err_v[ch]   = (sum_v[ch][EB] ? (sum_v[ch] + (EB+1)'(3)) : sum_v[ch]) >>> 2;
      row_sub[ch] = sat_err((EB+2)'(row_err[ch]) - (EB+2)'(err_v[ch]));
      col_sub[ch] = sat_err((EB+2)'(col_ch[ch]) - (EB+2)'(err_v[ch]));
      tgt_v[ch]   = TB'((EB+2)'($signed({1'b0, pix[ch]})) - (EB+2)'(err_v[ch]));
      diff_v[ch]  = (EB+2)'($signed({1'b0, pal_c[ch]}))
                  - (EB+2)'($signed({1'b0, pix[ch]}));
      row_add[ch] = sat_err((EB+2)'(row_err[ch]) + diff_v[ch]);
      col_add[ch] = sat_err((EB+2)'(colv[ch]) + diff_v[ch]);
    end
  end

  pqed_column_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .ERROR_BITS (ERROR_BITS)
  ) u_column_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (col_clear),
    .busy    (col_busy),
    .rd_addr (col_v),
    .rd_data (col_rd),
    .wr_en   (col_we),
    .wr_addr (col_v),
    .wr_data (col_wr)
  );

  pqed_palette_search #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .ERROR_BITS    (ERROR_BITS)
  ) u_palette_search (
    .clk               (clk),
    .rst               (rst),
    .start             (search_start),
    .tgt_red           (tgt[0]),
    .tgt_green         (tgt[1]),
    .tgt_blue          (tgt[2]),
    .palette_entries   (palette_entries),
    .transparent_index (transparent_index),
    .wr_en             (pal_wr),
    .wr_index          (s_tdata[7:0]),
    .wr_rgb            (pal_wr_rgb),
    .fetch             (pal_fetch),
    .fetch_index       (sel),
    .rd_rgb            (rd_rgb),
    .status            (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      m_tvalid          <= 1'b0;
      pos               <= '0;
      odd               <= 1'b0;
      row_err           <= '{default: '0};
      palette_entries   <= ENTRIES_RST;
      transparent_index <= TRANSPARENT_RST;
      image_width       <= WIDTH_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ENTRIES:     palette_entries   <= cfg_data[ENTRIES_W-1:0];
          CFG_TRANSPARENT: transparent_index <= cfg_data[INDEX_W-1:0];
          CFG_WIDTH:       image_width       <= cfg_data[IMG_W_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != ST_PUSH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (!col_busy) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            unique case (s_tuser)
              OP_START: begin
                row_err <= '{default: '0};
                pos     <= '0;
                odd     <= 1'b0;
                state   <= ST_CLEAR;
              end
              OP_PIXEL: begin
                pix[0] <= s_tdata[15:8];
                pix[1] <= s_tdata[23:16];
                pix[2] <= s_tdata[31:24];
                state  <= ST_ROW;
              end
              default: ;
            endcase
          end
        end
        ST_ROW: begin
          if (WC'(pos) >= width_eff) begin
            pos     <= '0;
            odd     <= ~odd;
            row_err <= '{default: '0};
          end
          state <= ST_COLRD;
        end
        ST_COLRD: begin
          state <= ST_ERR;
        end
        ST_ERR: begin
          row_err <= row_sub;
          colv    <= col_sub;
          tgt     <= tgt_v;
          state   <= ST_START;
        end
        ST_START: begin
          state <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (status.done) begin
            sel   <= status.index;
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          res_index <= sel;
          res_rgb   <= rd_rgb;
          if ((WC'(pos) + WC'(1)) >= width_eff) begin
            pos     <= '0;
            odd     <= ~odd;
            row_err <= '{default: '0};
          end else begin
            pos     <= pos + CA_BITS'(1);
            row_err <= row_add;
          end
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_rgb.blue, res_rgb.green, res_rgb.red, res_index};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_row_start_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && (pos == '0)) |->
      ((row_err[0] == '0) && (row_err[1] == '0) && (row_err[2] == '0)))
    else $error("Row error is not clear at the start of a row.");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    col_busy |-> !s_tready)
    else $error("Request taken during the column clearing pass.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_PUSH))
    else $error("Result appeared outside the output step.");

endmodule

FILE: tb/palette_quantizer_error_diffusion_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the palette quantizer with serpentine error diffusion
// Drives palette loads, image starts and pixels into the request stream and
// checks every result against a predictor that tracks the palette, the row
// and column error accumulators and the serpentine position. Directed tests
// cover the search extremes, ties, the transparent index, missing candidates
// and width changes, with one long receiver hold. Random images follow under
// random idling on both sides.
// ----------------------------------------------------------------------------
module palette_quantizer_error_diffusion_core_tb;
  import pqed_pkg::*;

  localparam int MAX_W         = 4096;
  localparam int DEPTH         = 256;
  localparam int ERR_BITS      = 12;
  localparam int ERR_MAX       = (1 << (ERR_BITS - 1)) - 1;
  localparam int ERR_MIN       = -ERR_MAX - 1;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 40000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 300;

  localparam logic [OP_W-1:0]      OP_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    rgb_t               color;
  } quantized_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata   = '0;
  logic [OP_W-1:0]       s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  palette_quantizer_error_diffusion_core #(
    .MAX_WIDTH    (MAX_W),
    .PALETTE_DEPTH(DEPTH),
    .ERROR_BITS   (ERR_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  rgb_t                 palette_copy [DEPTH];
  int                   col_acc [MAX_W][3];
  int                   row_acc [3];
  int                   col_pos = 0;
  bit                   odd_row = 1'b0;
  logic [ENTRIES_W-1:0] entries_reg     = ENTRIES_RST;
  logic [INDEX_W-1:0]   transparent_reg = TRANSPARENT_RST;
  logic [IMG_W_W-1:0]   width_reg       = WIDTH_RST;
  quantized_t           pending_colors [$];

  int gap_max         = 5;
  int sink_stall      = 0;
  bit hold_pending    = 1'b0;
  bit clear_pending   = 1'b1;
  int quiet_cycles    = 0;
  int mismatches      = 0;
  int results_checked = 0;
  int pixels_sent     = 0;
  int loads_sent      = 0;
  int starts_sent     = 0;
  int config_sets     = 0;
  int holds_done      = 0;

  function automatic int clamp_error(input int v);
    if (v > ERR_MAX) return ERR_MAX;
    if (v < ERR_MIN) return ERR_MIN;
    return v;
  endfunction

  function automatic int abs_diff(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int component(input rgb_t c, input int ch);
    if (ch == 0) return int'(c.red);
    if (ch == 1) return int'(c.green);
    return int'(c.blue);
  endfunction

  function automatic rgb_t random_color();
    logic [23:0] v;
    v = 24'($urandom);
    return v;
  endfunction

  function automatic void next_row();
    col_pos = 0;
    odd_row = !odd_row;
    row_acc = '{0, 0, 0};
  endfunction

  function automatic quantized_t quantize_pixel(input rgb_t pix);
    quantized_t result;
    rgb_t       chosen;
    int         width, col, count, best, best_dist, entry_dist, err, diff;
    int         target [3];
    bit         found;
    width = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : int'(width_reg));
    if (col_pos >= width) next_row();
    col = odd_row ? width - 1 - col_pos : col_pos;
    for (int ch = 0; ch < 3; ch++) begin
      err = (row_acc[ch] + col_acc[col][ch]) / 4;
      row_acc[ch] = clamp_error(row_acc[ch] - err);
      col_acc[col][ch] = clamp_error(col_acc[col][ch] - err);
      target[ch] = component(pix, ch) - err;
    end
    count = (entries_reg > DEPTH) ? DEPTH : int'(entries_reg);
    found = 1'b0;
    best = 0;
    best_dist = 0;
    for (int i = 0; i < count; i++) begin
      if (i == int'(transparent_reg)) continue;
      entry_dist = 0;
      for (int ch = 0; ch < 3; ch++) begin
        entry_dist += abs_diff(target[ch], component(palette_copy[i], ch));
      end
      if (!found || entry_dist < best_dist) begin
        found = 1'b1;
        best_dist = entry_dist;
        best = i;
      end
    end
    if (!found) best = int'(transparent_reg);
    chosen = palette_copy[best];
    for (int ch = 0; ch < 3; ch++) begin
      diff = component(chosen, ch) - component(pix, ch);
      row_acc[ch] = clamp_error(row_acc[ch] + diff);
      col_acc[col][ch] = clamp_error(col_acc[col][ch] + diff);
    end
    col_pos++;
    if (col_pos >= width) next_row();
    result.index = best[INDEX_W-1:0];
    result.color = chosen;
    return result;
  endfunction

  function automatic void apply_request(input logic [OP_W-1:0] op,
                                        input logic [S_DATA_W-1:0] data);
    rgb_t c;
    c.red   = data[15:8];
    c.green = data[23:16];
    c.blue  = data[31:24];
    case (op)
      OP_LOAD: begin
        palette_copy[data[7:0]] = c;
        loads_sent++;
      end
      OP_START: begin
        foreach (col_acc[x, ch]) col_acc[x][ch] = 0;
        row_acc = '{0, 0, 0};
        col_pos = 0;
        odd_row = 1'b0;
        clear_pending = 1'b1;
        starts_sent++;
      end
      OP_PIXEL: begin
        pending_colors.push_back(quantize_pixel(c));
        pixels_sent++;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result(input logic [M_DATA_W-1:0] data);
    quantized_t          want;
    logic [M_DATA_W-1:0] packed_want;
    string               names [4] = '{"color_index", "out_red", "out_green", "out_blue"};
    if (pending_colors.size() == 0) begin
      $display("%0t: result 0x%h arrived with no pixel outstanding", $time, data);
      mismatches++;
      return;
    end
    want = pending_colors.pop_front();
    results_checked++;
    packed_want = {want.color.blue, want.color.green, want.color.red, want.index};
    for (int f = 0; f < 4; f++) begin
      if (packed_want[8*f +: 8] !== data[8*f +: 8]) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, names[f],
                 packed_want[8*f +: 8], data[8*f +: 8]);
        mismatches++;
      end
    end
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] entry,
                              input rgb_t c);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {c.blue, c.green, c.red, entry};
    do @(posedge clk); while (!s_tready);
    apply_request(op, {c.blue, c.green, c.red, entry});
  endtask

  // Stops offering requests, waits for every outstanding result and lets any
  // column clearing pass finish before the registers may change.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (clear_pending ? MAX_W + SETTLE_CYCLES : SETTLE_CYCLES) @(posedge clk);
    clear_pending = 1'b0;
  endtask

  task automatic set_registers(input int entries, input int transparent, input int width);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_ENTRIES, CFG_TRANSPARENT, CFG_WIDTH, CFG_SPARE};
    val = '{CFG_DATA_W'(entries), CFG_DATA_W'(transparent), CFG_DATA_W'(width),
            CFG_DATA_W'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    entries_reg     = entries[ENTRIES_W-1:0];
    transparent_reg = transparent[INDEX_W-1:0];
    width_reg       = width[IMG_W_W-1:0];
    config_sets++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
        sink_stall = $urandom_range(0, gap_max);
      end else if (sink_stall > 0) begin
        sink_stall--;
      end
      if (hold_pending) begin
        sink_stall = HOLD_CYCLES;
        hold_pending = 1'b0;
        holds_done++;
      end
      m_tready <= (sink_stall == 0);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("** palette_quantizer_error_diffusion_core: FAILED **");
      $finish;
    end
  end

  // Black, white, a duplicate of each for ties, mid gray, and the top entry.
  task automatic test_search_basics();
    set_registers(5, 1, 3);
    send_request(OP_LOAD, 8'd0, 24'h000000);
    send_request(OP_LOAD, 8'd1, 24'hFFFFFF);
    send_request(OP_LOAD, 8'd2, 24'hFFFFFF);
    send_request(OP_LOAD, 8'd3, 24'h000000);
    send_request(OP_LOAD, 8'd4, 24'h808080);
    send_request(OP_LOAD, 8'd255, 24'h0FF055);
    send_request(OP_PIXEL, 8'd0, 24'h000000);
    send_request(OP_PIXEL, 8'd255, 24'hFFFFFF);
    send_request(OP_PIXEL, 8'd0, 24'h808080);
    send_request(OP_PIXEL, 8'd0, 24'h404040);
    send_request(OP_PIXEL, 8'd0, 24'hFF0080);
    send_request(OP_PIXEL, 8'd0, 24'h00FF7F);
    send_request(OP_PIXEL, 8'd0, 24'h7F7F7F);
    send_request(OP_RESERVED, 8'hA5, 24'h123456);
    send_request(OP_START, 8'd0, 24'h000000);
    send_request(OP_PIXEL, 8'd0, 24'h101010);
    send_request(OP_PIXEL, 8'd0, 24'hF0F0F0);
  endtask

  // Only the transparent entry is searched, then no entry at all.
  task automatic test_no_candidate();
    drain();
    set_registers(1, 0, 2);
    send_request(OP_PIXEL, 8'd0, 24'hFFFFFF);
    send_request(OP_PIXEL, 8'd0, 24'h336699);
    drain();
    set_registers(0, 255, 2);
    send_request(OP_PIXEL, 8'd0, 24'h000000);
    send_request(OP_PIXEL, 8'd0, 24'hC0C0C0);
  endtask

  // Shrinks the row below the current position, then uses a zero width.
  task automatic test_width_change();
    drain();
    set_registers(5, 1, 8);
    send_request(OP_START, 8'd0, 24'h000000);
    repeat (5) send_request(OP_PIXEL, INDEX_W'($urandom), random_color());
    drain();
    set_registers(5, 1, 3);
    repeat (2) send_request(OP_PIXEL, INDEX_W'($urandom), random_color());
    drain();
    set_registers(5, 1, 0);
    repeat (2) send_request(OP_PIXEL, INDEX_W'($urandom), random_color());
  endtask

  // Loads every entry, then searches with counts and widths past their range.
  task automatic test_full_palette();
    for (int i = 0; i < DEPTH; i++) send_request(OP_LOAD, i[INDEX_W-1:0], random_color());
    drain();
    set_registers(511, 255, 8191);
    send_request(OP_START, 8'd0, 24'h000000);
    repeat (4) send_request(OP_PIXEL, INDEX_W'($urandom), random_color());
    drain();
    set_registers(256, 0, 4096);
    repeat (3) send_request(OP_PIXEL, INDEX_W'($urandom), random_color());
  endtask

  // The receiver holds off while requests keep coming, with a palette load
  // slipped in among the pixels.
  task automatic test_backpressure();
    drain();
    set_registers(6, 2, 5);
    gap_max = 0;
    @(negedge clk) hold_pending = 1'b1;
    @(posedge clk);
    repeat (6) send_request(OP_PIXEL, INDEX_W'($urandom), random_color());
    send_request(OP_LOAD, 8'd3, random_color());
    repeat (6) send_request(OP_PIXEL, INDEX_W'($urandom), random_color());
    drain();
    gap_max = 5;
  endtask

  task automatic test_random_images();
    int sent, phase_len, pick, entries, width;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      pick = $urandom_range(0, 15);
      entries = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 256 :
                (pick == 3) ? 511 : $urandom_range(2, 24);
      pick = $urandom_range(0, 15);
      width = (pick == 0) ? 0 : (pick == 1) ? 4096 : (pick == 2) ? 8191 :
              (pick == 3) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      set_registers(entries, $urandom_range(0, 255), width);
      if ($urandom_range(0, 3) != 0) begin
        send_request(OP_START, INDEX_W'($urandom), random_color());
        sent++;
      end
      phase_len = (entries >= 256) ? $urandom_range(4, 10) : $urandom_range(15, 50);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 86) begin
          send_request(OP_PIXEL, INDEX_W'($urandom), random_color());
          sent++;
        end else if (pick < 93) begin
          send_request(OP_LOAD, INDEX_W'($urandom), random_color());
          sent++;
        end else if (pick < 97) begin
          send_request(OP_RESERVED, INDEX_W'($urandom), random_color());
        end else begin
          send_request(OP_START, INDEX_W'($urandom), random_color());
          sent++;
        end
      end
    end
    drain();
    gap_max = 5;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_search_basics();
    test_no_candidate();
    test_width_change();
    test_full_palette();
    test_backpressure();
    test_random_images();
    drain();
    $display("Run covered %0d pixels, %0d palette loads, %0d image starts, %0d register sets.",
             pixels_sent, loads_sent, starts_sent, config_sets);
    $display("Checked %0d results across %0d long receiver holds; %0d mismatches.",
             results_checked, holds_done, mismatches);
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("** palette_quantizer_error_diffusion_core: PASSED **");
    end else begin
      $display("** palette_quantizer_error_diffusion_core: FAILED **");
    end
    $finish;
  end

endmodule
